/* rtl/low_coverage_region_finder_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the low-coverage region finder
// Clocked on clk; the plain form is gated off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LOW_COVERAGE_REGION_FINDER_ASSERT_SVH
`define LOW_COVERAGE_REGION_FINDER_ASSERT_SVH

// Checked only out of reset
`define LCRF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked during reset as well
`define LCRF_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/lcrf_pkg.sv */
// ----------------------------------------------------------------------------
// lcrf_pkg
// Shared types and codes for the low-coverage region finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcrf_pkg;

	localparam int COV_BITS   = 16;
	localparam int START_BITS = 24;
	localparam int END_BITS   = 25;
	localparam int MINL_BITS  = 24;
	localparam int PAD_BITS   = 16;
	localparam int CFG_BITS   = 24;
	localparam int IDX_BITS   = 2;

	// register indexes on the configuration port
	localparam logic [IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [IDX_BITS-1:0] CFG_MIN_LEN   = 2'd1;
	localparam logic [IDX_BITS-1:0] CFG_PAD       = 2'd2;

	// result kinds
	localparam logic KIND_REGION = 1'b0;
	localparam logic KIND_END    = 1'b1;

	typedef struct packed {
		logic [COV_BITS-1:0]  threshold;
		logic [MINL_BITS-1:0] min_len;
		logic [PAD_BITS-1:0]  pad;
	} cfg_t;

	typedef struct packed {
		logic                  kind;
		logic [START_BITS-1:0] start;
		logic [END_BITS-1:0]   stop;
		logic                  fin;
	} result_t;

	// up to two results produced by a single request
	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} res_pair_t;

endpackage

`default_nettype wire

/* rtl/lcrf_scan.sv */
// ----------------------------------------------------------------------------
// lcrf_scan
// Input register, run tracking state and per-sample region decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcrf_scan
	import lcrf_pkg::*;
#(
	parameter int POSITION_BITS = 24
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [COV_BITS-1:0] coverage,
	input  wire logic                last_sample,
	input  wire cfg_t                cfg,
	input  wire logic                slots_free,
	output logic                     load,
	output res_pair_t                res
);

	// wide enough for position plus padding and for the minimum length
	localparam int CW = ((POSITION_BITS > MINL_BITS) ? POSITION_BITS : MINL_BITS) + 2;

	logic                     valid_s1;
	logic [COV_BITS-1:0]      cov_s1;
	logic                     last_s1;

	logic [POSITION_BITS-1:0] pos_q;
	logic                     in_run_q;
	logic [POSITION_BITS-1:0] run_start_q;

	logic                     accept;
	logic                     adv;
	logic                     low;
	logic                     close_ok;
	logic                     open_ok;
	logic [POSITION_BITS-1:0] cur_start;
	logic [CW-1:0]            pos_x, rs_x, cs_x, pad_x, min_x;
	logic [CW-1:0]            close_len, open_len, pad_start, close_end, open_end;
	result_t                  region, marker;

	assign accept = in_valid && !in_stall;

	always_comb begin
		low       = cov_s1 <= cfg.threshold;
		cur_start = in_run_q ? run_start_q : pos_q;
		pos_x     = CW'(pos_q);
		rs_x      = CW'(run_start_q);
		cs_x      = CW'(cur_start);
		pad_x     = CW'(cfg.pad);
		min_x     = CW'(cfg.min_len);

		close_len = pos_x - rs_x;
		close_ok  = in_run_q && !low && (close_len >= min_x);
		pad_start = (rs_x > pad_x) ? (rs_x - pad_x) : '0;
		close_end = pos_x + pad_x;

		open_end  = pos_x + CW'(1);
		open_len  = open_end - cs_x;
		open_ok   = last_s1 && low && (open_len >= min_x);

		region.kind  = KIND_REGION;
		region.start = close_ok ? pad_start[START_BITS-1:0] : cs_x[START_BITS-1:0];
		region.stop  = close_ok ? close_end[END_BITS-1:0] : open_end[END_BITS-1:0];
		region.fin   = !last_s1;

		marker.kind  = KIND_END;
		marker.start = '0;
		marker.stop  = '0;
		marker.fin   = 1'b1;

		res.v0 = close_ok || open_ok || last_s1;
		res.v1 = (close_ok || open_ok) && last_s1;
		res.r0 = (close_ok || open_ok) ? region : marker;
		res.r1 = marker;
	end

	// a sample with no result never waits on the output side
	assign adv      = valid_s1 && (!res.v0 || slots_free);
	assign in_stall = valid_s1 && !adv;
	assign load     = adv && res.v0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cov_s1  <= coverage;
			last_s1 <= last_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			in_run_q    <= 1'b0;
			run_start_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				pos_q       <= '0;
				in_run_q    <= 1'b0;
				run_start_q <= '0;
			end else begin
				in_run_q <= low;
				if (low && !in_run_q) begin
					run_start_q <= pos_q;
				end
				// position saturates at its maximum
				if (pos_q != '1) begin
					pos_q <= pos_q + POSITION_BITS'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/lcrf_out.sv */
// ----------------------------------------------------------------------------
// lcrf_out
// Two-slot result buffer: head register on the port, one pending behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcrf_out
	import lcrf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      load,
	input  wire res_pair_t res,
	output logic           slots_free,
	output logic           out_valid,
	input  wire logic      out_stall,
	output result_t        head
);

	logic    head_v_q;
	logic    pend_v_q;
	result_t head_q;
	result_t pend_q;
	logic    take;

	assign take       = head_v_q && !out_stall;
	assign slots_free = !head_v_q || (take && !pend_v_q);
	assign out_valid  = head_v_q;
	assign head       = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else if (load) begin
			head_v_q <= 1'b1;
			pend_v_q <= res.v1;
		end else if (take) begin
			head_v_q <= pend_v_q;
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			head_q <= res.r0;
			pend_q <= res.r1;
		end else if (take && pend_v_q) begin
			head_q <= pend_q;
		end
	end

endmodule

`default_nettype wire

/* rtl/low_coverage_region_finder.sv */
// ----------------------------------------------------------------------------
// low_coverage_region_finder
// Streams coverage samples and reports runs at or below a threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one request per position carrying
//   coverage and last_sample. Output channel (out_valid / out_stall): one
//   result per transfer; a request gives none, one or two results. Each
//   carries result_kind, region_start, region_end and final_result.
//   Configuration: cfg_we with cfg_index and cfg_data writes one register
//   (threshold, minimum length, padding) at a clock edge; write while idle.
// Result path: a sample is registered in the input register on acceptance;
//   any result it causes is loaded into the head register of the result
//   buffer, which drives the output, once the buffer has room.
// Throughput: one sample per cycle while the result buffer has room. A
//   sample closing a run or the last sample of a sequence needs the two-slot
//   result buffer free, so a last sample that reports a region and the end
//   marker fills both slots. Samples causing no result pass without waiting.
// Reset: clears valid flags, run state and position count, empties the
//   pipeline; configuration returns to zero.
// Stall: while out_stall is high the result holds; the input register
//   backs up and in_stall rises once a result-bearing sample cannot move.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module low_coverage_region_finder
	import lcrf_pkg::*;
#(
	parameter int POSITION_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// sample channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [COV_BITS-1:0]   coverage,
	input  wire logic                  last_sample,
	// result channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       result_kind,
	output logic [START_BITS-1:0]      region_start,
	output logic [END_BITS-1:0]        region_end,
	output logic                       final_result,
	// configuration writes
	input  wire logic                  cfg_we,
	input  wire logic [IDX_BITS-1:0]   cfg_index,
	input  wire logic [CFG_BITS-1:0]   cfg_data
);

	cfg_t      cfg_q;
	logic      slots_free;
	logic      load;
	res_pair_t res;
	result_t   head;

	// configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESHOLD: cfg_q.threshold <= cfg_data[COV_BITS-1:0];
				CFG_MIN_LEN:   cfg_q.min_len   <= cfg_data[MINL_BITS-1:0];
				CFG_PAD:       cfg_q.pad       <= cfg_data[PAD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// sample register, run tracking and region decision
	lcrf_scan #(
		.POSITION_BITS(POSITION_BITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.coverage    (coverage),
		.last_sample (last_sample),
		.cfg         (cfg_q),
		.slots_free  (slots_free),
		.load        (load),
		.res         (res)
	);

	// result buffer driving the output channel
	lcrf_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.res        (res),
		.slots_free (slots_free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.head       (head)
	);

	assign result_kind  = head.kind;
	assign region_start = head.start;
	assign region_end   = head.stop;
	assign final_result = head.fin;

	// ------------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------------
`include "low_coverage_region_finder_assert.svh"

	// end marker carries zero positions and always closes its request
	`LCRF_ASSERT(a_marker_fields, out_valid && (result_kind == KIND_END) |-> (region_start == '0) && (region_end == '0) && final_result, "end marker fields wrong")

	// a non-final result is directly followed by the end marker
	`LCRF_ASSERT(a_marker_follows, out_valid && !final_result && !out_stall |=> out_valid && (result_kind == KIND_END), "end marker missing after region")

	// nothing on the output while reset is held
	`LCRF_ASSERT_RST(a_reset_quiet, !arst_n |-> !out_valid, "result valid during reset")

endmodule

`default_nettype wire

/* dv/low_coverage_region_finder_tb.sv */
// ----------------------------------------------------------------------------
// low_coverage_region_finder_tb
// Self-checking bench for the low-coverage region finder. A directed table
// covers reset settings, register extremes, padding clamped at zero and runs
// closed by the last sample. A long random part of sample sequences follows,
// under several register settings. Both channels idle at random, and a long
// receiver hold-off fills the block. Every result is checked field by field
// against typed values or an in-bench model of the run tracking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module low_coverage_region_finder_tb;
	import lcrf_pkg::*;

	localparam int          POS_BITS      = 24;
	localparam int          RANDOM_ITEMS  = 1350;
	localparam int          PHASE_ITEMS   = 150;
	localparam int          SETTLE_CYCLES = 8;      // pipeline is two deep
	localparam int unsigned CYCLE_LIMIT   = 1_500_000;
	localparam int          BY_MODEL      = -1;     // row checked by the model
	localparam int          HOLD_CYCLES   = 400;

	localparam result_t END_MARK = '{KIND_END, '0, '0, 1'b1};

	typedef enum {ROW_SAMPLE, ROW_CONFIG} row_op_t;

	typedef struct {
		row_op_t              op;
		logic [COV_BITS-1:0]  cov;
		logic                 last;
		int                   known;    // typed results, or BY_MODEL
		result_t              r0;
		result_t              r1;
		logic [COV_BITS-1:0]  thr;
		logic [MINL_BITS-1:0] minl;
		logic [PAD_BITS-1:0]  pad;
	} row_t;

	// DUT signals; the inputs are known from time zero
	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b1;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic [COV_BITS-1:0]   coverage     = '0;
	logic                  last_sample  = 1'b0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic                  result_kind;
	logic [START_BITS-1:0] region_start;
	logic [END_BITS-1:0]   region_end;
	logic                  final_result;
	logic                  cfg_we       = 1'b0;
	logic [IDX_BITS-1:0]   cfg_index    = CFG_THRESHOLD;
	logic [CFG_BITS-1:0]   cfg_data     = '0;

	// model copy of the registers
	logic [COV_BITS-1:0]   low_limit = '0;
	logic [MINL_BITS-1:0]  min_run   = '0;
	logic [PAD_BITS-1:0]   pad_len   = '0;

	// model copy of the run tracking
	logic [POS_BITS-1:0]   scan_pos  = '0;
	logic                  run_open  = 1'b0;
	logic [POS_BITS-1:0]   run_first = '0;

	result_t     step_results[$];     // what the latest sample causes
	result_t     awaited_regions[$];  // results still to come, oldest first
	row_t        directed_rows[$];

	int          mismatches       = 0;
	int unsigned cycle_count      = 0;
	bit          steady_flow      = 1'b0; // no idling on either side
	bit          backpressure_req = 1'b0;

	low_coverage_region_finder #(
		.POSITION_BITS(POS_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.coverage     (coverage),
		.last_sample  (last_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.region_start (region_start),
		.region_end   (region_end),
		.final_result (final_result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// helpers
	// ------------------------------------------------------------------------
	function automatic result_t region(input int unsigned first, input int unsigned past,
			input logic fin);
		return '{KIND_REGION, START_BITS'(first), END_BITS'(past), fin};
	endfunction

	function automatic row_t sample_row(input logic [COV_BITS-1:0] cov, input logic last,
			input int known, input result_t r0, input result_t r1);
		row_t r;
		r       = '{op: ROW_SAMPLE, default: '0};
		r.op    = ROW_SAMPLE;
		r.cov   = cov;
		r.last  = last;
		r.known = known;
		r.r0    = r0;
		r.r1    = r1;
		return r;
	endfunction

	function automatic row_t config_row(input logic [COV_BITS-1:0] thr,
			input logic [MINL_BITS-1:0] minl, input logic [PAD_BITS-1:0] pad);
		row_t r;
		r      = '{op: ROW_CONFIG, default: '0};
		r.op   = ROW_CONFIG;
		r.thr  = thr;
		r.minl = minl;
		r.pad  = pad;
		return r;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return $urandom_range(1, 2);
		else if (roll < 90)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	task automatic flag_error(input string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		mismatches++;
	endtask

	// ------------------------------------------------------------------------
	// Run tracking model: fills step_results with what one sample causes.
	// A run closed by a high sample gets padding on both sides, start clamped
	// at zero; a run still open at the last sample is reported unpadded.
	// ------------------------------------------------------------------------
	function automatic void track_runs(input logic [COV_BITS-1:0] cov, input logic last);
		logic [POS_BITS-1:0]   here;
		logic [START_BITS-1:0] first;
		logic                  is_low;
		result_t               tail;
		here   = scan_pos;
		is_low = (cov <= low_limit);
		if (is_low && !run_open) begin
			run_open  = 1'b1;
			run_first = here;
		end else if (run_open && !is_low) begin
			if (32'(here) - 32'(run_first) >= 32'(min_run)) begin
				first = (run_first <= POS_BITS'(pad_len)) ? '0 : run_first - pad_len;
				step_results.push_back(region(first, 32'(here) + 32'(pad_len), 1'b1));
			end
			run_open = 1'b0;
		end
		if (last) begin
			if (run_open && (32'(here) + 1 - 32'(run_first) >= 32'(min_run)))
				step_results.push_back(region(run_first, 32'(here) + 1, 1'b0));
			// only the end marker closes the sequence
			if (step_results.size() > 0) begin
				tail     = step_results.pop_back();
				tail.fin = 1'b0;
				step_results.push_back(tail);
			end
			step_results.push_back(END_MARK);
			scan_pos  = '0;
			run_open  = 1'b0;
			run_first = '0;
		end else if (scan_pos != '1) begin
			scan_pos = scan_pos + 1'b1;   // saturates at the top position
		end
	endfunction

	// ------------------------------------------------------------------------
	// sample channel
	// ------------------------------------------------------------------------
	// Offers one request and waits for it to be taken. Called just after a
	// rising edge; returns just after the accepting edge.
	task automatic offer_sample(input logic [COV_BITS-1:0] cov, input logic last,
			input int known, input result_t r0, input result_t r1);
		int gap;
		gap = (steady_flow || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		coverage    <= cov;
		last_sample <= last;
		do @(posedge clk); while (in_stall);
		step_results.delete();
		track_runs(cov, last);
		if (known == BY_MODEL) begin
			foreach (step_results[i]) awaited_regions.push_back(step_results[i]);
		end else begin
			if (known > 0) awaited_regions.push_back(r0);
			if (known > 1) awaited_regions.push_back(r1);
		end
	endtask

	// sender stops and waits until every result is out and the pipe is empty
	task automatic drain_block();
		in_valid <= 1'b0;
		while (awaited_regions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// block must be idle; one register per edge
	task automatic write_registers(input logic [COV_BITS-1:0] thr,
			input logic [MINL_BITS-1:0] minl, input logic [PAD_BITS-1:0] pad);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_THRESHOLD;
		cfg_data  <= CFG_BITS'(thr);
		@(posedge clk);
		cfg_index <= CFG_MIN_LEN;
		cfg_data  <= CFG_BITS'(minl);
		@(posedge clk);
		cfg_index <= CFG_PAD;
		cfg_data  <= CFG_BITS'(pad);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		low_limit = thr;
		min_run   = minl;
		pad_len   = pad;
	endtask

	// ------------------------------------------------------------------------
	// result channel: check, then choose the stall for the next cycle
	// ------------------------------------------------------------------------
	initial begin
		int      hold_left;
		int      stall_left;
		int      flow_left;
		result_t seen;
		result_t want;
		hold_left  = 0;
		stall_left = 0;
		flow_left  = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				seen = '{result_kind, region_start, region_end, final_result};
				if (awaited_regions.size() == 0) begin
					flag_error($sformatf("result with nothing awaited: kind %0d start %0d end %0d",
						seen.kind, seen.start, seen.stop));
				end else begin
					want = awaited_regions.pop_front();
					if (seen.kind !== want.kind)
						flag_error($sformatf("result_kind %0d, want %0d", seen.kind, want.kind));
					if (seen.start !== want.start)
						flag_error($sformatf("region_start %0d, want %0d",
							seen.start, want.start));
					if (seen.stop !== want.stop)
						flag_error($sformatf("region_end %0d, want %0d", seen.stop, want.stop));
					if (seen.fin !== want.fin)
						flag_error($sformatf("final_result %0d, want %0d", seen.fin, want.fin));
				end
			end
			// long hold-off: the sender keeps going, so the block backs up
			if (backpressure_req) begin
				hold_left        = HOLD_CYCLES;
				backpressure_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (steady_flow) begin
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (flow_left > 0) begin
				flow_left--;
				out_stall <= 1'b0;
			end else begin
				stall_left = pick_gap();
				flow_left  = $urandom_range(1, 24);
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		int                   remaining;
		int                   phase;
		int                   budget;
		int                   seq_len;
		int                   roll;
		logic                 low_now;
		logic [COV_BITS-1:0]  cov;
		logic [COV_BITS-1:0]  thr;
		logic [MINL_BITS-1:0] minl;
		logic [PAD_BITS-1:0]  pad;

		// falling reset edge once every process is waiting
		arst_n <= 1'b0;

		// reset settings: threshold, minimum and padding all zero
		directed_rows.push_back(sample_row(16'h0000, 1'b1, 2, region(0, 1, 1'b0), END_MARK));
		directed_rows.push_back(sample_row(16'hFFFF, 1'b1, 1, END_MARK, END_MARK));
		directed_rows.push_back(sample_row(16'h0000, 1'b0, 0, END_MARK, END_MARK));
		directed_rows.push_back(sample_row(16'h0000, 1'b0, 0, END_MARK, END_MARK));
		directed_rows.push_back(sample_row(16'hFFFF, 1'b0, 1, region(0, 2, 1'b1), END_MARK));
		directed_rows.push_back(sample_row(16'h0001, 1'b0, 0, END_MARK, END_MARK));
		directed_rows.push_back(sample_row(16'h0000, 1'b0, 0, END_MARK, END_MARK));
		directed_rows.push_back(sample_row(16'h0000, 1'b1, 2, region(4, 6, 1'b0), END_MARK));
		// all registers at their top: every sample low, no run long enough
		directed_rows.push_back(config_row(16'hFFFF, 24'hFFFFFF, 16'hFFFF));
		directed_rows.push_back(sample_row(16'hFFFF, 1'b0, 0, END_MARK, END_MARK));
		directed_rows.push_back(sample_row(16'hFFFF, 1'b1, 1, END_MARK, END_MARK));
		// widest padding: start clamps at zero, closing run on the last sample
		directed_rows.push_back(config_row(16'd100, 24'd0, 16'hFFFF));
		directed_rows.push_back(sample_row(16'd0, 1'b0, 0, END_MARK, END_MARK));
		directed_rows.push_back(sample_row(16'd101, 1'b0, 1, region(0, 65536, 1'b1), END_MARK));
		directed_rows.push_back(sample_row(16'd100, 1'b0, 0, END_MARK, END_MARK));
		directed_rows.push_back(sample_row(16'hFFFF, 1'b1, 2, region(0, 65538, 1'b0), END_MARK));
		// minimum length three: short run dropped, padded run, open run at end
		directed_rows.push_back(config_row(16'd1000, 24'd3, 16'd2));
		directed_rows.push_back(sample_row(16'd0,     1'b0, BY_MODEL, END_MARK, END_MARK));
		directed_rows.push_back(sample_row(16'd500,   1'b0, BY_MODEL, END_MARK, END_MARK));
		directed_rows.push_back(sample_row(16'd1001,  1'b0, BY_MODEL, END_MARK, END_MARK));
		directed_rows.push_back(sample_row(16'd0,     1'b0, BY_MODEL, END_MARK, END_MARK));
		directed_rows.push_back(sample_row(16'd1000,  1'b0, BY_MODEL, END_MARK, END_MARK));
		directed_rows.push_back(sample_row(16'd7,     1'b0, BY_MODEL, END_MARK, END_MARK));
		directed_rows.push_back(sample_row(16'd40000, 1'b0, BY_MODEL, END_MARK, END_MARK));
		directed_rows.push_back(sample_row(16'd0,     1'b0, BY_MODEL, END_MARK, END_MARK));
		directed_rows.push_back(sample_row(16'd0,     1'b0, BY_MODEL, END_MARK, END_MARK));
		directed_rows.push_back(sample_row(16'd0,     1'b1, BY_MODEL, END_MARK, END_MARK));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].op == ROW_CONFIG) begin
				drain_block();
				write_registers(directed_rows[i].thr, directed_rows[i].minl,
					directed_rows[i].pad);
			end else begin
				offer_sample(directed_rows[i].cov, directed_rows[i].last,
					directed_rows[i].known, directed_rows[i].r0, directed_rows[i].r1);
			end
		end

		// random sequences, one register setting per phase
		remaining = RANDOM_ITEMS;
		phase     = 0;
		while (remaining > 0) begin
			case (phase)
				0: begin
					thr  = '0;
					minl = '0;
					pad  = 16'hFFFF;
				end
				1: begin
					thr  = 16'hFFFF;
					minl = 24'd1;
					pad  = '0;
				end
				2: begin
					thr  = 16'($urandom_range(0, 65535));
					minl = 24'hFFFFFF;
					pad  = 16'($urandom_range(0, 65535));
				end
				default: begin
					case ($urandom_range(0, 3))
						0: thr = 16'($urandom_range(0, 15));
						1: thr = 16'($urandom_range(0, 65535));
						2: thr = 16'hFFFF;
						default: thr = 16'($urandom_range(1000, 40000));
					endcase
					roll = $urandom_range(0, 99);
					if (roll < 70)
						minl = 24'($urandom_range(0, 6));
					else if (roll < 90)
						minl = 24'($urandom_range(7, 40));
					else
						minl = 24'($urandom_range(0, 24'hFFFFFF));
					roll = $urandom_range(0, 99);
					if (roll < 40)
						pad = 16'($urandom_range(0, 4));
					else if (roll < 70)
						pad = 16'($urandom_range(0, 65535));
					else if (roll < 85)
						pad = 16'hFFFF;
					else
						pad = '0;
				end
			endcase
			drain_block();
			write_registers(thr, minl, pad);
			steady_flow = (phase != 1) && ($urandom_range(0, 3) == 0);
			if (phase == 1)
				backpressure_req = 1'b1;

			budget = PHASE_ITEMS;
			while (budget > 0 && remaining > 0) begin
				seq_len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 250)
					: $urandom_range(1, 24);
				low_now = 1'($urandom_range(0, 1));
				for (int k = 0; k < seq_len; k++) begin
					if ($urandom_range(0, 99) < 30)
						low_now = !low_now;
					// now and then a fully random count, else stay on one side
					if ($urandom_range(0, 9) == 0)
						cov = 16'($urandom_range(0, 65535));
					else if (low_now || low_limit == 16'hFFFF)
						cov = 16'($urandom_range(0, int'(low_limit)));
					else
						cov = 16'($urandom_range(int'(low_limit) + 1, 65535));
					offer_sample(cov, k == seq_len - 1, BY_MODEL, END_MARK, END_MARK);
				end
				budget    -= seq_len;
				remaining -= seq_len;
			end
			phase++;
		end

		drain_block();
		if (awaited_regions.size() != 0)
			flag_error($sformatf("%0d results never came", awaited_regions.size()));
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/lcrf_pkg.sv
rtl/lcrf_scan.sv
rtl/lcrf_out.sv
rtl/low_coverage_region_finder.sv
dv/low_coverage_region_finder_tb.sv
